### rtl/xtd_pkg.sv
// Shared types and constants for the XML text entity decoder.
package xtd_pkg;

    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SAT = 21'h110000;
    localparam logic [CP_W-1:0] CP_LIM1 = 21'h000080;
    localparam logic [CP_W-1:0] CP_LIM2 = 21'h000800;
    localparam logic [CP_W-1:0] CP_LIM3 = 21'h010000;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT = 8'h80;

    localparam int NAME_BYTES = 4;

    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    localparam logic [15:0] NAME_LT = "lt";
    localparam logic [15:0] NAME_GT = "gt";
    localparam logic [23:0] NAME_AMP = "amp";
    localparam logic [31:0] NAME_QUOT = "quot";
    localparam logic [31:0] NAME_APOS = "apos";

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_W = QUEUE_PTR_W + 1;

    typedef enum logic [2:0] {
        STATUS_OK = 3'd0,
        STATUS_MALFORMED = 3'd1,
        STATUS_UNKNOWN_NAME = 3'd2,
        STATUS_BAD_REF = 3'd3,
        STATUS_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PS_BASE,
        PS_SPACE,
        PS_SIGNED,
        PS_ZERO,
        PS_ZERO_X,
        PS_DIGITS,
        PS_STOP
    } parse_state_t;

    typedef struct packed {
        logic raw;
        status_t status;
        logic [CP_W-1:0] cp;
    } cmd_t;

endpackage

### rtl/xtd_front.sv
// Front end: accepts text bytes, tracks entities, parses references, issues commands.
module xtd_front #(
    parameter int MAX_BODY_BYTES = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     text_byte,
    input  logic           end_of_text,
    input  logic           q_full,
    output logic           cmd_push,
    output xtd_pkg::cmd_t  cmd
);

    localparam int LEN_W = $clog2(MAX_BODY_BYTES + 1);

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c inside {[8'h30:8'h39]})
        begin
            d = 5'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = 5'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    logic                       in_entity_reg, in_entity_next;
    logic                       error_seen_reg, error_seen_next;
    logic [LEN_W-1:0]           body_length_reg, body_length_next;
    logic [7:0]                 name_reg [xtd_pkg::NAME_BYTES];
    xtd_pkg::parse_state_t      pstate_reg, pstate_next;
    logic                       hex_reg, hex_next;
    logic                       neg_reg, neg_next;
    logic                       have_digit_reg, have_digit_next;
    logic [xtd_pkg::CP_W-1:0]   value_reg, value_next;

    logic                       take;
    logic                       body_full;
    logic                       store;
    logic                       is_x;
    logic                       is_sign;
    logic [4:0]                 dv;
    logic                       is_digit;
    logic [xtd_pkg::CP_W+4:0]   prod;
    logic [xtd_pkg::CP_W+4:0]   sum;
    logic [xtd_pkg::CP_W-1:0]   acc;
    logic                       run_signed;
    logic                       run_digit;

    assign take = push && !q_full;
    assign body_full = (body_length_reg >= LEN_W'(MAX_BODY_BYTES));
    assign store = take && !error_seen_reg && in_entity_reg
                   && (text_byte != xtd_pkg::CH_SEMI) && !body_full;

    assign is_x = (text_byte == xtd_pkg::CH_LOWER_X) || (text_byte == xtd_pkg::CH_UPPER_X);
    assign is_sign = (text_byte == xtd_pkg::CH_PLUS) || (text_byte == xtd_pkg::CH_MINUS);
    assign dv = digit_value(text_byte);
    assign is_digit = hex_reg ? (dv < 5'd16) : (dv < 5'd10);
    assign prod = hex_reg ? {1'b0, value_reg, 4'b0000}
                          : ({4'b0, value_reg, 1'b0} + {2'b0, value_reg, 3'b000});
    assign sum = prod + {21'b0, dv};
    assign acc = (sum > {5'b0, xtd_pkg::CP_MAX}) ? xtd_pkg::CP_SAT : sum[xtd_pkg::CP_W-1:0];

    // Reference parser: next state
    always_comb
    begin
        pstate_next = pstate_reg;
        hex_next = hex_reg;
        neg_next = neg_reg;
        have_digit_next = have_digit_reg;
        value_next = value_reg;
        run_signed = 1'b0;
        run_digit = 1'b0;
        if (store && (body_length_reg == '0))
        begin
            pstate_next = xtd_pkg::PS_BASE;
            hex_next = 1'b0;
            neg_next = 1'b0;
            have_digit_next = 1'b0;
            value_next = '0;
        end
        else if (store)
        begin
            case (pstate_reg)
                xtd_pkg::PS_BASE, xtd_pkg::PS_SPACE:
                begin
                    if ((pstate_reg == xtd_pkg::PS_BASE) && is_x)
                    begin
                        hex_next = 1'b1;
                        pstate_next = xtd_pkg::PS_SPACE;
                    end
                    else if (is_space(text_byte))
                    begin
                        pstate_next = xtd_pkg::PS_SPACE;
                    end
                    else if (is_sign)
                    begin
                        neg_next = (text_byte == xtd_pkg::CH_MINUS);
                        pstate_next = xtd_pkg::PS_SIGNED;
                    end
                    else
                    begin
                        run_signed = 1'b1;
                    end
                end
                xtd_pkg::PS_SIGNED:
                begin
                    run_signed = 1'b1;
                end
                xtd_pkg::PS_ZERO:
                begin
                    if (is_x)
                    begin
                        pstate_next = xtd_pkg::PS_ZERO_X;
                    end
                    else
                    begin
                        run_digit = 1'b1;
                    end
                end
                xtd_pkg::PS_ZERO_X, xtd_pkg::PS_DIGITS:
                begin
                    run_digit = 1'b1;
                end
                default:
                begin
                    pstate_next = xtd_pkg::PS_STOP;
                end
            endcase
            if (run_signed)
            begin
                if (hex_reg && (text_byte == xtd_pkg::CH_ZERO))
                begin
                    have_digit_next = 1'b1;
                    pstate_next = xtd_pkg::PS_ZERO;
                end
                else
                begin
                    run_digit = 1'b1;
                end
            end
            if (run_digit)
            begin
                if (is_digit)
                begin
                    value_next = acc;
                    have_digit_next = 1'b1;
                    pstate_next = xtd_pkg::PS_DIGITS;
                end
                else
                begin
                    pstate_next = xtd_pkg::PS_STOP;
                end
            end
        end
    end

    // Command output
    always_comb
    begin
        cmd_push = 1'b0;
        cmd.raw = 1'b1;
        cmd.status = xtd_pkg::STATUS_OK;
        cmd.cp = '0;
        if (take && !error_seen_reg)
        begin
            if (!in_entity_reg)
            begin
                if (text_byte == xtd_pkg::CH_AMP)
                begin
                    if (end_of_text)
                    begin
                        cmd_push = 1'b1;
                        cmd.status = xtd_pkg::STATUS_MALFORMED;
                    end
                end
                else
                begin
                    cmd_push = 1'b1;
                    cmd.cp = {13'b0, text_byte};
                end
            end
            else if (text_byte == xtd_pkg::CH_SEMI)
            begin
                cmd_push = 1'b1;
                if ((body_length_reg == LEN_W'(2))
                    && ({name_reg[0], name_reg[1]} == xtd_pkg::NAME_LT))
                begin
                    cmd.cp = {13'b0, xtd_pkg::CH_LT};
                end
                else if ((body_length_reg == LEN_W'(2))
                         && ({name_reg[0], name_reg[1]} == xtd_pkg::NAME_GT))
                begin
                    cmd.cp = {13'b0, xtd_pkg::CH_GT};
                end
                else if ((body_length_reg == LEN_W'(3))
                         && ({name_reg[0], name_reg[1], name_reg[2]} == xtd_pkg::NAME_AMP))
                begin
                    cmd.cp = {13'b0, xtd_pkg::CH_AMP};
                end
                else if ((body_length_reg == LEN_W'(4))
                         && ({name_reg[0], name_reg[1], name_reg[2], name_reg[3]}
                             == xtd_pkg::NAME_QUOT))
                begin
                    cmd.cp = {13'b0, xtd_pkg::CH_QUOT};
                end
                else if ((body_length_reg == LEN_W'(4))
                         && ({name_reg[0], name_reg[1], name_reg[2], name_reg[3]}
                             == xtd_pkg::NAME_APOS))
                begin
                    cmd.cp = {13'b0, xtd_pkg::CH_APOS};
                end
                else if ((body_length_reg != '0) && (name_reg[0] == xtd_pkg::CH_HASH))
                begin
                    if (!have_digit_reg)
                    begin
                        cmd.status = xtd_pkg::STATUS_BAD_REF;
                    end
                    else if (neg_reg || (value_reg == '0) || (value_reg > xtd_pkg::CP_MAX))
                    begin
                        cmd.status = xtd_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        cmd.raw = 1'b0;
                        cmd.cp = value_reg;
                    end
                end
                else
                begin
                    cmd.status = xtd_pkg::STATUS_UNKNOWN_NAME;
                end
            end
            else if (body_full || end_of_text)
            begin
                cmd_push = 1'b1;
                cmd.status = xtd_pkg::STATUS_MALFORMED;
            end
        end
    end

    // Entity tracking: next state
    always_comb
    begin
        in_entity_next = in_entity_reg;
        error_seen_next = error_seen_reg;
        body_length_next = body_length_reg;
        if (take)
        begin
            if (end_of_text)
            begin
                in_entity_next = 1'b0;
                error_seen_next = 1'b0;
                body_length_next = '0;
            end
            else if (!error_seen_reg)
            begin
                if (cmd_push && (cmd.status != xtd_pkg::STATUS_OK))
                begin
                    error_seen_next = 1'b1;
                end
                if (!in_entity_reg)
                begin
                    if (text_byte == xtd_pkg::CH_AMP)
                    begin
                        in_entity_next = 1'b1;
                        body_length_next = '0;
                    end
                end
                else if ((text_byte == xtd_pkg::CH_SEMI) || body_full)
                begin
                    in_entity_next = 1'b0;
                    body_length_next = '0;
                end
                else
                begin
                    body_length_next = body_length_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg <= 1'b0;
            error_seen_reg <= 1'b0;
            body_length_reg <= '0;
            pstate_reg <= xtd_pkg::PS_BASE;
            hex_reg <= 1'b0;
            neg_reg <= 1'b0;
            have_digit_reg <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            in_entity_reg <= in_entity_next;
            error_seen_reg <= error_seen_next;
            body_length_reg <= body_length_next;
            pstate_reg <= pstate_next;
            hex_reg <= hex_next;
            neg_reg <= neg_next;
            have_digit_reg <= have_digit_next;
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < xtd_pkg::NAME_BYTES; k++)
        begin
            if (store && (body_length_reg == LEN_W'(k)))
            begin
                name_reg[k] <= text_byte;
            end
        end
    end

endmodule

### rtl/xtd_queue.sv
// Command queue between the front end and the back end.
module xtd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  xtd_pkg::cmd_t  wr_cmd,
    input  logic           rd_en,
    output xtd_pkg::cmd_t  rd_cmd,
    output logic           q_full,
    output logic           q_empty
);

    xtd_pkg::cmd_t                      slot_reg [xtd_pkg::QUEUE_DEPTH];
    logic [xtd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [xtd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [xtd_pkg::QUEUE_COUNT_W-1:0]  count_reg, count_next;
    logic                               do_wr;
    logic                               do_rd;

    assign q_full = (count_reg == xtd_pkg::QUEUE_COUNT_W'(xtd_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr = wr_en && !q_full;
    assign do_rd = rd_en && !q_empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == xtd_pkg::QUEUE_PTR_W'(xtd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + xtd_pkg::QUEUE_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == xtd_pkg::QUEUE_PTR_W'(xtd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + xtd_pkg::QUEUE_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + xtd_pkg::QUEUE_COUNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - xtd_pkg::QUEUE_COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= xtd_pkg::QUEUE_COUNT_W'(xtd_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");
`endif

endmodule

### rtl/xtd_back.sv
// Back end: expands commands into result bytes and holds the output register.
module xtd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  xtd_pkg::cmd_t  head_cmd,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic [2:0]     status,
    output logic           last
);

    logic [1:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    xtd_pkg::status_t   out_status_reg;
    logic               out_last_reg;

    logic               head_valid;
    logic               out_ready;
    logic               emit;
    logic [1:0]         last_idx;
    logic [7:0]         enc [4];
    logic [7:0]         emit_byte;
    logic               emit_last;

    assign head_valid = !q_empty;
    assign out_ready = !out_valid_reg || pop;
    assign emit = head_valid && out_ready;

    always_comb
    begin
        enc[0] = head_cmd.cp[7:0];
        enc[1] = '0;
        enc[2] = '0;
        enc[3] = '0;
        last_idx = 2'd0;
        if (head_cmd.raw || (head_cmd.status != xtd_pkg::STATUS_OK)
            || (head_cmd.cp < xtd_pkg::CP_LIM1))
        begin
            last_idx = 2'd0;
        end
        else if (head_cmd.cp < xtd_pkg::CP_LIM2)
        begin
            last_idx = 2'd1;
            enc[0] = xtd_pkg::UTF8_LEAD2 | {3'b0, head_cmd.cp[10:6]};
            enc[1] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[5:0]};
        end
        else if (head_cmd.cp < xtd_pkg::CP_LIM3)
        begin
            last_idx = 2'd2;
            enc[0] = xtd_pkg::UTF8_LEAD3 | {4'b0, head_cmd.cp[15:12]};
            enc[1] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[11:6]};
            enc[2] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[5:0]};
        end
        else
        begin
            last_idx = 2'd3;
            enc[0] = xtd_pkg::UTF8_LEAD4 | {5'b0, head_cmd.cp[20:18]};
            enc[1] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[17:12]};
            enc[2] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[11:6]};
            enc[3] = xtd_pkg::UTF8_CONT | {2'b0, head_cmd.cp[5:0]};
        end
    end

    assign emit_byte = enc[idx_reg];
    assign emit_last = (idx_reg == last_idx);
    assign q_pop = emit && emit_last;

    always_comb
    begin
        idx_next = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            idx_next = emit_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_status_reg <= head_cmd.status;
            out_last_reg <= emit_last;
        end
    end

    assign empty = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign status = out_status_reg;
    assign last = out_last_reg;

`ifndef SYNTHESIS
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != xtd_pkg::STATUS_OK))
        |-> (out_last_reg && (out_byte_reg == 8'd0)))
        else $error("error result not a single zero byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= last_idx))
        else $error("byte index past end of encoding");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == 2'd0))
        else $error("byte index not cleared with empty queue");
`endif

endmodule

### rtl/xml_text_entity_decoder.sv
// Top level of the XML text entity decoder.
// A command from an accepted item is written to the command queue, then expanded into the output register.
// Throughput: one item per cycle while the command queue is not full; a character reference
// holds the output stage for each of its UTF-8 bytes (one to four) in turn, set by the single output register.
// Reset: clears entity state, parser, command queue and output register;
// buffered entity bytes are not cleared.
module xml_text_entity_decoder #(
    parameter int MAX_BODY_BYTES = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic        last
);

    logic           cmd_push;
    xtd_pkg::cmd_t  cmd;
    xtd_pkg::cmd_t  head_cmd;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    assign full = q_full;

    xtd_front #(
        .MAX_BODY_BYTES(MAX_BODY_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    xtd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd),
        .rd_en   (q_pop),
        .rd_cmd  (head_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    xtd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .status   (status),
        .last     (last)
    );

endmodule
